@@ rtl/core/hmv_pkg.sv @@
// shared types, constants and sha-256 helpers of the hmac message verifier
package hmv_pkg;

    localparam int DEF_RING_DEPTH = 64;
    localparam int DEF_MAC_BYTES  = 16;
    localparam int DEF_KEY_BYTES  = 32;

    localparam logic [15:0] SKEW_RESET  = 16'd60;
    localparam logic [39:0] EPOCH_RESET = 40'd1700000000;

    // command codes
    localparam logic [1:0] CMD_BODY   = 2'd0;
    localparam logic [1:0] CMD_VERIFY = 2'd1;
    localparam logic [1:0] CMD_SIGN   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FAIL  = 2'd1;
    localparam logic [1:0] STS_NOKEY = 2'd2;

    // register indexes
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_KVAL  = 3'd4;
    localparam logic [2:0] REG_SKEW  = 3'd5;
    localparam logic [2:0] REG_EPOCH = 3'd6;

    typedef logic [7:0][31:0] t_hash;   // word 0 is h0
    typedef logic [0:63][7:0] t_blk;    // byte 0 is the most significant

    typedef enum logic [1:0] {
        CS_IPAD,
        CS_OPAD,
        CS_BUF,
        CS_OUTER
    } t_csel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_KEY_I,
        S_KEY_IW,
        S_KEY_O,
        S_KEY_OW,
        S_BODY,
        S_BFULL,
        S_BWAIT,
        S_PAD,
        S_FIN1,
        S_FIN1W,
        S_LEN,
        S_FIN2,
        S_FIN2W,
        S_OUTER,
        S_OUTERW,
        S_SCAN,
        S_SCANW,
        S_RESULT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic  accept;
        logic  byte_wr;
        logic  start;
        t_csel csel;
        logic  pad;
        logic  len_blk;
        logic  scan_start;
        logic  result;
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic       key_dirty;
        logic       key_valid;
        logic [1:0] cmd;
        logic       bytes_none;
        logic       fill_full;
        logic       two_blk;
        logic       cmp_done;
        logic       scan_done;
        logic       out_free;
    } t_sts;

    localparam t_hash HINIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ rtl/core/hmv_ram.sv @@
// generic single write port ram with registered read
module hmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/hmv_sha.sv @@
// iterative sha-256 compression unit, one round per cycle
module hmv_sha
    import hmv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_hash        i_h,
    input  logic [511:0] i_blk,
    output logic         o_done,
    output t_hash        o_h
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_rnd;
    t_hash             r_v;
    t_hash             r_hin;
    logic [15:0][31:0] r_w;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    always_comb begin
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + SHA_K[r_rnd] + r_w[0];
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = r_w[0] + sml_s0(r_w[1]) + r_w[9] + sml_s1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_h;
            r_hin <= i_h;
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= i_blk[511-32*j -: 32];
            end
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_new;
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_h[j] = r_hin[j] + r_v[j];
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/hmv_ctrl.sv @@
// sequencing state machine of the hmac message verifier
module hmv_ctrl
    import hmv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_cfg_ready,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   can_accept;

    // a configuration write never shares an edge with an input transaction
    assign can_accept  = (r_state == S_IDLE) && !i_sts.key_dirty;
    assign o_in_stall  = !can_accept;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.key_dirty) begin
                    n_state = S_KEY_I;
                end else if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.cmd == CMD_BODY) begin
                    n_state = S_BODY;
                end else if (i_sts.cmd == CMD_CLEAR || !i_sts.key_valid) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_KEY_I:  n_state = S_KEY_IW;
            S_KEY_IW: if (i_sts.cmp_done) n_state = S_KEY_O;
            S_KEY_O:  n_state = S_KEY_OW;
            S_KEY_OW: if (i_sts.cmp_done) n_state = S_IDLE;
            S_BODY: begin
                if (i_sts.bytes_none) begin
                    n_state = S_IDLE;
                end else if (i_sts.fill_full) begin
                    n_state = S_BFULL;
                end
            end
            S_BFULL:  n_state = S_BWAIT;
            S_BWAIT:  if (i_sts.cmp_done) n_state = S_BODY;
            S_PAD:    n_state = S_FIN1;
            S_FIN1:   n_state = S_FIN1W;
            S_FIN1W: begin
                if (i_sts.cmp_done) begin
                    n_state = i_sts.two_blk ? S_LEN : S_OUTER;
                end
            end
            S_LEN:    n_state = S_FIN2;
            S_FIN2:   n_state = S_FIN2W;
            S_FIN2W:  if (i_sts.cmp_done) n_state = S_OUTER;
            S_OUTER:  n_state = S_OUTERW;
            S_OUTERW: begin
                if (i_sts.cmp_done) begin
                    n_state = (i_sts.cmd == CMD_SIGN) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN:   n_state = S_SCANW;
            S_SCANW:  if (i_sts.scan_done) n_state = S_RESULT;
            S_RESULT: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.csel       = CS_BUF;
        o_ctl.accept     = can_accept && i_in_valid;
        case (r_state)
            S_KEY_I: begin
                o_ctl.start = 1'b1;
                o_ctl.csel  = CS_IPAD;
            end
            S_KEY_O: begin
                o_ctl.start = 1'b1;
                o_ctl.csel  = CS_OPAD;
            end
            S_BODY:   o_ctl.byte_wr = !i_sts.bytes_none;
            S_BFULL:  o_ctl.start = 1'b1;
            S_PAD:    o_ctl.pad = 1'b1;
            S_FIN1:   o_ctl.start = 1'b1;
            S_LEN:    o_ctl.len_blk = 1'b1;
            S_FIN2:   o_ctl.start = 1'b1;
            S_OUTER: begin
                o_ctl.start = 1'b1;
                o_ctl.csel  = CS_OUTER;
            end
            S_SCAN:   o_ctl.scan_start = 1'b1;
            S_RESULT: o_ctl.result = i_sts.out_free;
            default:  o_ctl.start = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/hmv_datapath.sv @@
// registers, hashing, nonce ring and result stage of the hmac message verifier
module hmv_datapath
    import hmv_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int MAC_BYTES  = DEF_MAC_BYTES,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    output t_sts                o_sts,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic [1:0]          i_cmd,
    input  logic [63:0]         i_data,
    input  logic [3:0]          i_data_bytes,
    input  logic [31:0]         i_nonce,
    input  logic signed [39:0]  i_msg_time,
    input  logic [39:0]         i_wall_time,
    input  logic [63:0]         i_sig_hi,
    input  logic [63:0]         i_sig_lo,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [63:0]         o_mac_hi,
    output logic [63:0]         o_mac_lo
);

    localparam int RW       = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
    localparam int USED     = MAC_BYTES < 16 ? MAC_BYTES : 16;
    localparam int KB       = KEY_BYTES < 32 ? KEY_BYTES : 32;
    localparam logic [255:0] KEY_MASK = {256{1'b1}} << (8 * (32 - KB));
    localparam logic [127:0] MAC_MASK = {128{1'b1}} << (8 * (16 - USED));
    localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);

    // configuration
    logic [3:0][63:0] r_key;
    logic             r_key_valid;
    logic [15:0]      r_skew;
    logic [39:0]      r_epoch;
    logic             r_key_dirty;

    // captured transaction
    logic [1:0]        r_cmd;
    logic [0:7][7:0]   r_data;
    logic [3:0]        r_nb;
    logic [3:0]        r_bk;
    logic [31:0]       r_nonce;
    logic [39:0]       r_wall;
    logic signed [41:0] r_diff;
    logic [127:0]      r_sig;

    // hashing state
    t_hash       r_h;
    t_hash       r_ipad;
    t_hash       r_opad;
    t_hash       r_o;
    t_blk        r_blk;
    logic [5:0]  r_fill;
    logic [63:0] r_count;
    logic        r_two;
    logic        r_tfail;
    t_csel       r_csel;

    // nonce ring
    logic [RING_DEPTH-1:0] r_rvalid;
    logic [RW-1:0]         r_head;
    logic [RW-1:0]         r_scan_addr;
    logic                  r_scan_on;
    logic                  r_cmp_v;
    logic                  r_cmp_last;
    logic [RW-1:0]         r_cmp_idx;
    logic                  r_found;
    logic [31:0]           ring_rdata;
    logic                  ring_we;

    // result register
    logic         r_out_valid;
    logic [1:0]   r_status;
    logic [127:0] r_mac;

    // sha unit
    logic         sha_start;
    t_hash        sha_hin;
    logic [511:0] sha_blk;
    logic         sha_done;
    t_hash        sha_hout;

    logic [255:0] key_bytes;
    logic [63:0]  len_bits;
    logic [63:0]  cnt_plus;
    t_blk         pad_blk;
    logic [41:0]  skew_abs;
    logic [127:0] mac_full;
    logic         mac_fail;
    logic         verify_fail;
    logic         out_free;

    assign key_bytes = {r_key[0], r_key[1], r_key[2], r_key[3]} & KEY_MASK;
    assign cnt_plus  = r_count + 64'd64;
    assign len_bits  = {cnt_plus[60:0], 3'b000};
    assign skew_abs  = r_diff[41] ? 42'(-r_diff) : 42'(r_diff);
    assign mac_full  = {r_o[0], r_o[1], r_o[2], r_o[3]};
    assign mac_fail  = |((mac_full ^ r_sig) & MAC_MASK);
    assign verify_fail = r_tfail || r_found || mac_fail;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        pad_blk = r_blk;
        for (int b = 0; b < 64; b++) begin
            if (6'(b) == r_fill) begin
                pad_blk[b] = 8'h80;
            end else if (6'(b) > r_fill) begin
                pad_blk[b] = 8'h00;
            end
        end
        if (r_fill < 6'd56) begin
            for (int b = 0; b < 8; b++) begin
                pad_blk[56+b] = len_bits[63-8*b -: 8];
            end
        end
    end

    always_comb begin
        sha_start = i_ctl.start;
        case (i_ctl.csel)
            CS_IPAD: begin
                sha_hin = HINIT;
                sha_blk = {key_bytes, 256'b0} ^ {64{8'h36}};
            end
            CS_OPAD: begin
                sha_hin = HINIT;
                sha_blk = {key_bytes, 256'b0} ^ {64{8'h5c}};
            end
            CS_OUTER: begin
                sha_hin = r_opad;
                sha_blk = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7],
                           8'h80, 184'b0, 64'd768};
            end
            default: begin
                sha_hin = r_h;
                sha_blk = r_blk;
            end
        endcase
    end

    hmv_sha u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sha_start),
        .i_h     (sha_hin),
        .i_blk   (sha_blk),
        .o_done  (sha_done),
        .o_h     (sha_hout)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_key_valid <= 1'b0;
            r_skew      <= SKEW_RESET;
            r_epoch     <= EPOCH_RESET;
            r_key_dirty <= 1'b1;
        end else begin
            if (i_ctl.start && i_ctl.csel == CS_IPAD) begin
                r_key_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY0: begin
                        r_key[0]    <= i_cfg_data;
                        r_key_dirty <= 1'b1;
                    end
                    REG_KEY1: begin
                        r_key[1]    <= i_cfg_data;
                        r_key_dirty <= 1'b1;
                    end
                    REG_KEY2: begin
                        r_key[2]    <= i_cfg_data;
                        r_key_dirty <= 1'b1;
                    end
                    REG_KEY3: begin
                        r_key[3]    <= i_cfg_data;
                        r_key_dirty <= 1'b1;
                    end
                    REG_KVAL:  r_key_valid <= i_cfg_data[0];
                    REG_SKEW:  r_skew      <= i_cfg_data[15:0];
                    REG_EPOCH: r_epoch     <= i_cfg_data[39:0];
                    default:   r_key_valid <= r_key_valid;
                endcase
            end
        end
    end

    // transaction capture and timestamp check, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_data  <= i_data;
            r_nb    <= (i_data_bytes > 4'd8) ? 4'd8 : i_data_bytes;
            r_nonce <= i_nonce;
            r_wall  <= i_wall_time;
            r_diff  <= $signed({2'b00, i_wall_time}) - 42'(i_msg_time);
            r_sig   <= {i_sig_hi, i_sig_lo};
        end
        if (i_ctl.pad) begin
            r_tfail <= (r_wall > r_epoch) && (skew_abs > {26'b0, r_skew});
        end
    end

    // message hashing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_bk    <= '0;
            r_csel  <= CS_BUF;
        end else begin
            if (i_ctl.accept) begin
                r_bk <= '0;
            end
            if (i_ctl.start) begin
                r_csel <= i_ctl.csel;
            end
            if (i_ctl.byte_wr) begin
                r_fill  <= r_fill + 6'd1;
                r_count <= r_count + 64'd1;
                r_bk    <= r_bk + 4'd1;
            end
            if (sha_done && r_csel == CS_IPAD) begin
                r_fill  <= '0;
                r_count <= '0;
            end
            if (i_ctl.result && r_cmd != CMD_CLEAR) begin
                r_fill  <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_wr) begin
            r_blk[r_fill] <= r_data[r_bk[2:0]];
        end
        if (i_ctl.pad) begin
            r_blk <= pad_blk;
            r_two <= (r_fill >= 6'd56);
        end
        if (i_ctl.len_blk) begin
            r_blk <= {448'b0, len_bits};
        end
        if (sha_done) begin
            case (r_csel)
                CS_IPAD: begin
                    r_ipad <= sha_hout;
                    r_h    <= sha_hout;
                end
                CS_OPAD:  r_opad <= sha_hout;
                CS_OUTER: r_o    <= sha_hout;
                default:  r_h    <= sha_hout;
            endcase
        end
        if (i_ctl.result && r_cmd != CMD_CLEAR) begin
            r_h <= r_ipad;
        end
    end

    // nonce ring scan and update
    assign ring_we = i_ctl.result && r_cmd == CMD_VERIFY && r_key_valid && !verify_fail;

    hmv_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wdata (r_nonce),
        .i_raddr (r_scan_addr),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid    <= '0;
            r_head      <= '0;
            r_scan_on   <= 1'b0;
            r_scan_addr <= '0;
            r_cmp_v     <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_v    <= r_scan_on;
            r_cmp_last <= r_scan_on && (r_scan_addr == RING_LAST);
            if (i_ctl.scan_start) begin
                r_scan_on   <= 1'b1;
                r_scan_addr <= '0;
                r_found     <= 1'b0;
            end else if (r_scan_on) begin
                if (r_scan_addr == RING_LAST) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + RW'(1);
                end
            end
            if (r_cmp_v && r_rvalid[r_cmp_idx] && ring_rdata == r_nonce && r_nonce != 32'd0) begin
                r_found <= 1'b1;
            end
            if (ring_we) begin
                r_rvalid[r_head] <= 1'b1;
                r_head <= (r_head == RING_LAST) ? '0 : r_head + RW'(1);
            end
            if (i_ctl.result && r_cmd == CMD_CLEAR) begin
                r_rvalid <= '0;
                r_head   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_addr;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.result) begin
            r_mac <= '0;
            if (r_cmd == CMD_CLEAR) begin
                r_status <= STS_OK;
            end else if (!r_key_valid) begin
                r_status <= STS_NOKEY;
            end else if (r_cmd == CMD_SIGN) begin
                r_status <= STS_OK;
                r_mac    <= mac_full & MAC_MASK;
            end else begin
                r_status <= verify_fail ? STS_FAIL : STS_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_mac_hi    = r_mac[127:64];
    assign o_mac_lo    = r_mac[63:0];

    always_comb begin
        o_sts            = '0;
        o_sts.key_dirty  = r_key_dirty;
        o_sts.key_valid  = r_key_valid;
        o_sts.cmd        = r_cmd;
        o_sts.bytes_none = (r_bk >= r_nb);
        o_sts.fill_full  = (r_fill == 6'd63);
        o_sts.two_blk    = r_two;
        o_sts.cmp_done   = sha_done;
        o_sts.scan_done  = r_cmp_v && r_cmp_last;
        o_sts.out_free   = out_free;
    end

endmodule

@@ rtl/core/hmac_message_verifier_replay_guard_core.sv @@
// top level of the truncated hmac-sha256 message verifier with nonce replay guard
//
// Streams message body bytes (up to eight per body transaction) into an
// hmac-sha256 keyed by the configured key, and on a finish transaction either
// returns the truncated mac (sign) or checks timestamp skew, nonce replay and
// the mac (verify); a clear transaction empties the nonce ring. Body
// transactions give no result, every other command gives exactly one. One
// sha-256 compression unit does all hashing at one round per cycle. A body
// transaction writes its bytes into the block buffer and, when it completes a
// 64-byte block, waits for that block to be compressed. A sign pads the
// message (into a second block when the padding spills over), finishes the
// inner hash and runs the outer hash; a verify then adds a scan of all
// RING_DEPTH entries of the nonce ring, and a clear or a finish without a key
// goes straight to the result. After reset, and after any write to a key word,
// the block precomputes the inner and outer pad states before it takes the
// next transaction. Configuration writes are taken only while the block is
// idle and no input transaction is offered (o_cfg_ready). The result register
// lets the next body transaction in while a result still waits to be taken.
module hmac_message_verifier_replay_guard_core
    import hmv_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int MAC_BYTES  = DEF_MAC_BYTES,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [63:0]        i_data,
    input  logic [3:0]         i_data_bytes,
    input  logic [31:0]        i_nonce,
    input  logic signed [39:0] i_msg_time,
    input  logic [39:0]        i_wall_time,
    input  logic [63:0]        i_sig_hi,
    input  logic [63:0]        i_sig_lo,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [63:0]        o_mac_hi,
    output logic [63:0]        o_mac_lo,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    hmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_ctl       (ctl)
    );

    // datapath: key schedule, sha unit, nonce ring and result register
    hmv_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAC_BYTES  (MAC_BYTES),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_data       (i_data),
        .i_data_bytes (i_data_bytes),
        .i_nonce      (i_nonce),
        .i_msg_time   (i_msg_time),
        .i_wall_time  (i_wall_time),
        .i_sig_hi     (i_sig_hi),
        .i_sig_lo     (i_sig_lo),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_mac_hi     (o_mac_hi),
        .o_mac_lo     (o_mac_lo)
    );

`ifndef NO_ASSERTIONS
    // an accepted transaction is decoded before another may enter
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("transaction accepted while previous one is decoded");

    // a configuration write and an input transaction never share an edge
    a_cfg_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !(i_in_valid && !o_in_stall))
        else $error("configuration written together with an input transaction");

    // a body transaction never raises a result right after it
    a_body_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_cmd == CMD_BODY) |=> !$rose(o_out_valid))
        else $error("body transaction produced a result");
`endif

endmodule
